FILE: sv/ssdbm_pkg.sv
// shared types and constants for the block-matching scorer with sorted best list
package ssdbm_pkg;

    localparam int PIX_W    = 8;
    localparam int SQ_W     = 2 * PIX_W;
    localparam int DIST_W   = 21;
    localparam int IDX_W    = 4;
    localparam int POS_W    = 10;
    localparam int KEEP_W   = 3;
    localparam int KEY_W    = DIST_W + IDX_W + 2 * POS_W;

    localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(5);
    localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};

    // sort key: compared as one vector, distance first, then index, row, column
    typedef struct packed {
        logic [DIST_W-1:0] score;
        logic [IDX_W-1:0]  idx;
        logic [POS_W-1:0]  top;
        logic [POS_W-1:0]  left;
    } t_key;

    // side info of one row request traveling beside the lane products
    typedef struct packed {
        logic              cend;
        logic              bend;
        logic [IDX_W-1:0]  idx;
        logic [POS_W-1:0]  top;
        logic [POS_W-1:0]  left;
    } t_ctl;

    // merge stage to best list: a finished candidate and/or a block end
    typedef struct packed {
        logic  ins;
        logic  bend;
        t_key  key;
    } t_ins;

endpackage

FILE: sv/ssdbm_lane.sv
// one pixel lane: squared difference of a subject and a reference pixel
module ssdbm_lane
    import ssdbm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [PIX_W-1:0] i_subj,
    input  logic [PIX_W-1:0] i_refp,
    output logic [SQ_W-1:0]  o_sq
);

    logic [PIX_W-1:0] absdiff;
    logic [SQ_W-1:0]  r_sq;

    // absolute difference keeps the multiplier unsigned 8x8
    assign absdiff = (i_subj >= i_refp) ? (i_subj - i_refp) : (i_refp - i_subj);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= SQ_W'(absdiff) * SQ_W'(absdiff);
        end
    end

    assign o_sq = r_sq;

endmodule

FILE: sv/ssdbm_merge.sv
// merges lane products into the row sum and keeps the running candidate distance
module ssdbm_merge
    import ssdbm_pkg::*;
#(
    parameter int PATCH_SIDE = 5
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  t_ctl            i_ctl,
    input  logic [SQ_W-1:0] i_sq [PATCH_SIDE],
    output t_ins            o_ins
);

    localparam int ROW_W = SQ_W + $clog2(PATCH_SIDE);

    logic [ROW_W-1:0]    row_sum;
    logic [DIST_W:0]     acc_sum;
    logic [DIST_W-1:0]   sat_sum;
    logic [DIST_W-1:0]   r_running;
    t_ins                r_ins;

    // sum of lane products (PATCH_SIDE narrow terms)
    always_comb begin
        row_sum = '0;
        for (int i = 0; i < PATCH_SIDE; i++) begin
            row_sum = row_sum + ROW_W'(i_sq[i]);
        end
    end

    // accumulate with saturation
    assign acc_sum = (DIST_W + 1)'(r_running) + (DIST_W + 1)'(row_sum);
    assign sat_sum = acc_sum[DIST_W] ? DIST_MAX : acc_sum[DIST_W-1:0];

    // running distance clears at candidate end and at block end;
    // candidate key takes its position from the row that ends the candidate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= '0;
            r_ins.ins <= 1'b0;
            r_ins.bend <= 1'b0;
        end else begin
            r_ins.ins <= i_valid && i_ctl.cend;
            r_ins.bend <= i_valid && i_ctl.bend;
            if (i_valid) begin
                r_running <= (i_ctl.cend || i_ctl.bend) ? '0 : sat_sum;
            end
        end
        if (i_valid) begin
            r_ins.key.score <= sat_sum;
            r_ins.key.idx   <= i_ctl.idx;
            r_ins.key.top   <= i_ctl.top;
            r_ins.key.left  <= i_ctl.left;
        end
    end

    assign o_ins = r_ins;

endmodule

FILE: sv/ssdbm_best_list.sv
// sorted best list: parallel compare insertion and ranked readout
module ssdbm_best_list
    import ssdbm_pkg::*;
#(
    parameter int BEST_DEPTH = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ins              i_ins,
    input  logic [KEEP_W-1:0] i_keep,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_key              o_key,
    output logic              o_last,
    output logic              o_done
);

    localparam int CNT_W = $clog2(BEST_DEPTH + 1);
    localparam int SEL_W = (BEST_DEPTH > 1) ? $clog2(BEST_DEPTH) : 1;

    typedef enum logic {S_FILL, S_EMIT} t_state;

    t_state             r_state;
    t_key               r_list [BEST_DEPTH];
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_emit;
    logic               r_out_valid;
    t_key               r_out_key;
    logic               r_out_last;

    logic [CNT_W-1:0]   lim;
    logic [CNT_W-1:0]   n_used;
    logic [CNT_W:0]     n_plus;
    logic [CNT_W-1:0]   n_count;
    logic [BEST_DEPTH-1:0] le;
    logic [BEST_DEPTH-1:0] prev_le;
    t_key               prev_entry [BEST_DEPTH];
    logic               dropped;
    logic               do_ins;
    logic               out_free;
    logic               emit_load;
    logic               emit_last;
    logic               emit_done;

    // effective keep count: zero acts as one, clipped to the list depth
    always_comb begin
        if (i_keep == '0) begin
            lim = CNT_W'(1);
        end else if (32'(i_keep) > BEST_DEPTH) begin
            lim = CNT_W'(BEST_DEPTH);
        end else begin
            lim = CNT_W'(i_keep);
        end
    end

    assign n_used = (r_count < lim) ? r_count : lim;

    // per-slot compare: entries at or below the new key stay in place
    always_comb begin
        for (int i = 0; i < BEST_DEPTH; i++) begin
            le[i] = (CNT_W'(i) < n_used) && (r_list[i] <= i_ins.key);
        end
        prev_le[0] = 1'b1;
        prev_entry[0] = i_ins.key;
        for (int i = 1; i < BEST_DEPTH; i++) begin
            prev_le[i] = le[i-1];
            prev_entry[i] = r_list[i-1];
        end
    end

    // new key is dropped when every kept slot holds a better or equal entry
    always_comb begin
        dropped = 1'b0;
        for (int i = 0; i < BEST_DEPTH; i++) begin
            if ((CNT_W'(i) + CNT_W'(1) == lim) && le[i]) begin
                dropped = 1'b1;
            end
        end
    end

    assign do_ins  = (r_state == S_FILL) && i_ins.ins;
    assign n_plus  = (CNT_W + 1)'(n_used) + (CNT_W + 1)'(1);
    assign n_count = dropped ? n_used :
                     ((n_plus < (CNT_W + 1)'(lim)) ? n_plus[CNT_W-1:0] : lim);

    // insertion shifts the tail down by one slot
    always_ff @(posedge i_clk) begin
        if (do_ins && !dropped) begin
            for (int i = 0; i < BEST_DEPTH; i++) begin
                if (!le[i]) begin
                    r_list[i] <= prev_le[i] ? i_ins.key : prev_entry[i];
                end
            end
        end
    end

    // readout control
    assign out_free  = !r_out_valid || i_out_ready;
    assign emit_last = (r_emit + CNT_W'(1)) == n_used;
    assign emit_load = (r_state == S_EMIT) && (n_used != '0) && out_free;
    assign emit_done = (r_state == S_EMIT) && ((n_used == '0) || (out_free && emit_last));

    // state, count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_count     <= '0;
            r_emit      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_FILL: begin
                    if (do_ins) begin
                        r_count <= n_count;
                    end
                    if (i_ins.bend) begin
                        r_state <= S_EMIT;
                        r_emit  <= '0;
                    end
                end
                S_EMIT: begin
                    if (emit_done) begin
                        r_state <= S_FILL;
                        r_count <= '0;
                        r_emit  <= '0;
                    end else if (emit_load) begin
                        r_emit <= r_emit + CNT_W'(1);
                    end
                end
                default: begin
                    r_state <= S_FILL;
                end
            endcase
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_out_key  <= r_list[r_emit[SEL_W-1:0]];
            r_out_last <= emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_key       = r_out_key;
    assign o_last      = r_out_last;
    assign o_done      = emit_done;

    // list never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= BEST_DEPTH)
        else $error("best list count above depth");

    // no candidate arrives while the list is being read out
    a_no_ins_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !i_ins.ins)
        else $error("insertion during readout");

    // a finished readout leaves an empty list
    a_clear_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_done |=> (r_count == '0) && (r_state == S_FILL))
        else $error("list not cleared after readout");

    // readout index stays inside the used part of the list
    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_load |-> (r_emit < n_used))
        else $error("readout index out of range");

endmodule

FILE: sv/ssd_block_match_top_k_top.sv
// top level of the block-matching scorer with sorted best-k list
//
// Input channel (i_in_valid / o_in_ready) takes one patch row per request:
// PATCH_SIDE subject and reference pixels, the candidate's image index and
// position, and the candidate-end and block-end flags. One pixel lane per
// column computes a squared difference; the merge stage sums the lanes and
// accumulates the candidate distance; the best list inserts a finished
// candidate with a parallel compare. Throughput is one row request per cycle
// while o_in_ready is high. A candidate's last row passes the lane and merge
// registers to reach the list. After a request with block end, o_in_ready
// stays low until the list has been read out: the block end passes the lane,
// merge, list state and output registers, then results are shown one per
// cycle while the receiver takes them, up to the effective keep count, the
// final one marked by o_last. A block with an empty list yields no result.
// When the receiver stalls, the output register holds its result and the
// readout waits. The keep-count register port is always ready and takes
// effect for later insertions and readouts. Synchronous reset clears the
// running distance, the list count and the pipeline and sets keep count to 5.
module ssd_block_match_top_k_top
    import ssdbm_pkg::*;
#(
    parameter int PATCH_SIDE = 5,
    parameter int BEST_DEPTH = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [KEEP_W-1:0]           i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [PATCH_SIDE*PIX_W-1:0] i_subject_row,
    input  logic [PATCH_SIDE*PIX_W-1:0] i_reference_row,
    input  logic [IDX_W-1:0]            i_ref_index,
    input  logic [POS_W-1:0]            i_ref_top,
    input  logic [POS_W-1:0]            i_ref_left,
    input  logic                        i_candidate_end,
    input  logic                        i_block_end,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [DIST_W-1:0]           o_distance,
    output logic [IDX_W-1:0]            o_match_index,
    output logic [POS_W-1:0]            o_match_top,
    output logic [POS_W-1:0]            o_match_left,
    output logic                        o_last
);

    logic              in_accept;
    logic [KEEP_W-1:0] r_keep;
    logic              r_blk_busy;
    logic              r_s1_valid;
    t_ctl              r_s1_ctl;
    logic [SQ_W-1:0]   lane_sq [PATCH_SIDE];
    t_ins              ins;
    t_key              out_key;
    logic              list_done;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_blk_busy;
    assign in_accept   = i_in_valid && o_in_ready;

    // keep-count register and block busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep     <= KEEP_RESET;
            r_blk_busy <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_keep <= i_cfg_data;
            end
            if (in_accept && i_block_end) begin
                r_blk_busy <= 1'b1;
            end else if (list_done) begin
                r_blk_busy <= 1'b0;
            end
            r_s1_valid <= in_accept;
        end
    end

    // side info beside the lane stage
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_ctl.cend <= i_candidate_end;
            r_s1_ctl.bend <= i_block_end;
            r_s1_ctl.idx  <= i_ref_index;
            r_s1_ctl.top  <= i_ref_top;
            r_s1_ctl.left <= i_ref_left;
        end
    end

    // pixel lanes
    for (genvar g = 0; g < PATCH_SIDE; g++) begin : g_lane
        ssdbm_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (in_accept),
            .i_subj (i_subject_row[g*PIX_W +: PIX_W]),
            .i_refp (i_reference_row[g*PIX_W +: PIX_W]),
            .o_sq   (lane_sq[g])
        );
    end

    // lane merge and distance accumulation
    ssdbm_merge #(
        .PATCH_SIDE (PATCH_SIDE)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .i_ctl   (r_s1_ctl),
        .i_sq    (lane_sq),
        .o_ins   (ins)
    );

    // sorted best list and readout
    ssdbm_best_list #(
        .BEST_DEPTH (BEST_DEPTH)
    ) u_list (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ins       (ins),
        .i_keep      (r_keep),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_key       (out_key),
        .o_last      (o_last),
        .o_done      (list_done)
    );

    assign o_distance    = out_key.score;
    assign o_match_index = out_key.idx;
    assign o_match_top   = out_key.top;
    assign o_match_left  = out_key.left;

endmodule
